FILE: rtl/core/pmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmx_pkg
// Shared widths, word types and control types for the PMX crossover core.
// ----------------------------------------------------------------------------
package pmx_pkg;

    localparam int ROW_LEN    = 9;
    localparam int VALUE_BITS = 4;
    localparam int ROW_W      = ROW_LEN * VALUE_BITS;
    localparam int CUT_W      = 4;
    localparam int STEP_W     = $clog2(ROW_LEN);

    typedef struct packed {
        logic [ROW_W-1:0] first_row;
        logic [ROW_W-1:0] second_row;
        logic [CUT_W-1:0] cut_a;
        logic [CUT_W-1:0] cut_b;
    } pmx_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] child_row;
        logic             invalid;
    } pmx_out_t;

    // one position of the parent pair as it travels round the ring
    typedef struct packed {
        logic [VALUE_BITS-1:0] p1;
        logic [VALUE_BITS-1:0] p2;
        logic                  seg;
    } pmx_lane_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic first_round;
        logic self_step;
    } pmx_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } pmx_state_t;

endpackage

FILE: rtl/core/pmx_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmx_cell
// One ring position: holds its own parent pair, checks the pairs passing by
// for repeats and missing values, and chases its working value through the
// segment mapping.
// ----------------------------------------------------------------------------
module pmx_cell import pmx_pkg::*; (
    input  logic                  aclk,
    input  pmx_ctl_t              ctl,
    input  pmx_lane_t             own_in,
    input  pmx_lane_t             next_in,
    output pmx_lane_t             lane_out,
    output logic [VALUE_BITS-1:0] p1_out,
    output logic [VALUE_BITS-1:0] child_out,
    output logic                  bad_out
);

    pmx_lane_t             own_reg,   own_next;
    pmx_lane_t             lane_reg,  lane_next;
    logic [VALUE_BITS-1:0] work_reg,  work_next;
    logic                  dup_reg,   dup_next;
    logic                  found_reg, found_next;

    always_comb begin
        own_next   = own_reg;
        lane_next  = lane_reg;
        work_next  = work_reg;
        dup_next   = dup_reg;
        found_next = found_reg;
        if (ctl.load) begin
            own_next   = own_in;
            lane_next  = own_in;
            work_next  = own_in.p2;
            dup_next   = 1'b0;
            found_next = 1'b0;
        end else if (ctl.eval) begin
            lane_next = next_in;
            if (ctl.first_round) begin
                if (!ctl.self_step && (lane_reg.p1 == own_reg.p1 ||
                                       lane_reg.p2 == own_reg.p2)) begin
                    dup_next = 1'b1;
                end
                if (lane_reg.p1 == own_reg.p2) begin
                    found_next = 1'b1;
                end
            end
            // follow the mapping while the value sits in the first parent's segment
            if (lane_reg.seg && lane_reg.p1 == work_reg) begin
                work_next = lane_reg.p2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        own_reg   <= own_next;
        lane_reg  <= lane_next;
        work_reg  <= work_next;
        dup_reg   <= dup_next;
        found_reg <= found_next;
    end

    assign lane_out  = lane_reg;
    assign p1_out    = own_reg.p1;
    assign child_out = own_reg.seg ? own_reg.p1 : work_reg;
    assign bad_out   = dup_reg | ~found_reg;

endmodule

FILE: rtl/core/pmx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmx_ctrl
// Sequencer for the cell ring: loads a word, runs full rotations of the ring
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module pmx_ctrl import pmx_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    output logic     out_load,
    output pmx_ctl_t ctl
);

    localparam logic [STEP_W-1:0] LAST = STEP_W'(ROW_LEN - 1);

    pmx_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [STEP_W-1:0] round_reg, round_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            round_reg <= round_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        ctl        = '0;
        ctl.first_round = (round_reg == '0);
        ctl.self_step   = (step_reg == '0);
        case (state_reg)
            ST_IDLE: begin
                // hold off the input while reset is held
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    ctl.load   = 1'b1;
                    step_next  = '0;
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                ctl.eval = 1'b1;
                if (step_reg == LAST) begin
                    step_next  = '0;
                    round_next = round_reg + 1'b1;
                    if (round_reg == LAST) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // hold until the output register can take the word
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/partially_mapped_crossover_row_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partially_mapped_crossover_row_core
// An accepted word is loaded into the ring, then the ROW_LEN-cell ring runs
// ROW_LEN full rotations, one shift per cycle, and the drain state waits for
// the output register; no new word is taken until the result is handed over.
// The output register holds a finished word while the next one is taken.
// Reset (aresetn low, synchronous) clears the sequencer and m_valid only.
// ----------------------------------------------------------------------------
module partially_mapped_crossover_row_core import pmx_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pmx_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output pmx_out_t m_word
);

    localparam logic [CUT_W-1:0] CUT_MAX = CUT_W'(ROW_LEN - 1);

    pmx_ctl_t              ctl;
    logic                  out_load;
    logic                  out_free;
    logic [CUT_W-1:0]      cut_a_sat, cut_b_sat, cut_lo, cut_hi;
    pmx_lane_t             own_in   [ROW_LEN];
    pmx_lane_t             lane_out [ROW_LEN];
    logic [VALUE_BITS-1:0] p1_val   [ROW_LEN];
    logic [VALUE_BITS-1:0] ch_val   [ROW_LEN];
    logic [ROW_LEN-1:0]    bad_vec;
    logic [ROW_W-1:0]      child_row, first_row;

    logic     m_valid_reg, m_valid_next;
    pmx_out_t m_word_reg,  m_word_next;

    assign cut_a_sat = (s_word.cut_a > CUT_MAX) ? CUT_MAX : s_word.cut_a;
    assign cut_b_sat = (s_word.cut_b > CUT_MAX) ? CUT_MAX : s_word.cut_b;
    assign cut_lo    = (cut_a_sat < cut_b_sat) ? cut_a_sat : cut_b_sat;
    assign cut_hi    = (cut_a_sat < cut_b_sat) ? cut_b_sat : cut_a_sat;

    assign out_free = ~m_valid_reg | m_ready;

    pmx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .out_load (out_load),
        .ctl      (ctl)
    );

    for (genvar j = 0; j < ROW_LEN; j++) begin : g_cell
        assign own_in[j].p1  = s_word.first_row[j*VALUE_BITS +: VALUE_BITS];
        assign own_in[j].p2  = s_word.second_row[j*VALUE_BITS +: VALUE_BITS];
        assign own_in[j].seg = (CUT_W'(j) >= cut_lo) && (CUT_W'(j) <= cut_hi);

        pmx_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .own_in    (own_in[j]),
            .next_in   (lane_out[(j + 1) % ROW_LEN]),
            .lane_out  (lane_out[j]),
            .p1_out    (p1_val[j]),
            .child_out (ch_val[j]),
            .bad_out   (bad_vec[j])
        );

        assign child_row[j*VALUE_BITS +: VALUE_BITS] = ch_val[j];
        assign first_row[j*VALUE_BITS +: VALUE_BITS] = p1_val[j];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (out_load) begin
            m_valid_next        = 1'b1;
            m_word_next.invalid = |bad_vec;
            m_word_next.child_row = (|bad_vec) ? first_row : child_row;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

FILE: rtl/core/pmx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmx_checker
// Port-level checks on the PMX crossover core, bound to the top level.
// ----------------------------------------------------------------------------
module pmx_checker import pmx_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input pmx_out_t m_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // one word in flight: busy straight after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in flight");

    // ready stays up until a word is taken
    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid |=> s_ready)
        else $error("ready dropped without an accept");

    // a new result frees the ring in the same cycle
    a_free_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result issued while the ring is still busy");

endmodule

bind partially_mapped_crossover_row_core pmx_checker u_pmx_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PMX crossover core. Parent pairs are driven
// through the input valid/ready channel. A scoreboard predicts each child
// word, including the invalid flag for parents that are not permutations of
// one another. Each returned word is compared against the oldest prediction.
// Sender gaps and receiver stalls vary across three phases.
// ----------------------------------------------------------------------------
module tb_top;
    import pmx_pkg::*;

    localparam int POOL_N        = 1 << VALUE_BITS;
    localparam int POOL_W        = POOL_N * VALUE_BITS;
    localparam int MAX_CUT       = (1 << CUT_W) - 1;
    localparam int WATCHDOG_LIM  = 2000;
    localparam int DRAIN_CYCLES  = 100;

    class crossover_checker;
        pmx_out_t pending_children[$];
        int mismatches    = 0;
        int words_in      = 0;
        int words_checked = 0;
        int invalid_words = 0;
        int clamped_cuts  = 0;

        function pmx_out_t predict_child(pmx_in_t w);
            logic [VALUE_BITS-1:0] p1  [ROW_LEN];
            logic [VALUE_BITS-1:0] p2  [ROW_LEN];
            logic [VALUE_BITS-1:0] kid [ROW_LEN];
            bit                    filled [ROW_LEN];
            logic [POOL_N-1:0]     set1, set2;
            bit                    distinct, present;
            int                    ca, cb, lo, hi, pos, idx;
            pmx_out_t              r;
            ca = w.cut_a;
            cb = w.cut_b;
            if (ca >= ROW_LEN) ca = ROW_LEN - 1;
            if (cb >= ROW_LEN) cb = ROW_LEN - 1;
            lo = (ca < cb) ? ca : cb;
            hi = (ca < cb) ? cb : ca;
            set1 = '0;
            set2 = '0;
            distinct = 1;
            for (int i = 0; i < ROW_LEN; i++) begin
                p1[i] = w.first_row[i*VALUE_BITS +: VALUE_BITS];
                p2[i] = w.second_row[i*VALUE_BITS +: VALUE_BITS];
                if (set1[p1[i]] || set2[p2[i]]) distinct = 0;
                set1[p1[i]] = 1'b1;
                set2[p2[i]] = 1'b1;
            end
            if (!distinct || set1 != set2) begin
                r.child_row = w.first_row;
                r.invalid   = 1'b1;
                return r;
            end
            for (int i = 0; i < ROW_LEN; i++) begin
                filled[i] = (i >= lo && i <= hi);
                kid[i]    = filled[i] ? p1[i] : '0;
            end
            for (int i = lo; i <= hi; i++) begin
                present = 0;
                for (int j = lo; j <= hi; j++)
                    if (p1[j] == p2[i]) present = 1;
                if (!present) begin
                    // chase second->first until the position falls outside the segment
                    pos = i;
                    for (int step = 0; step < ROW_LEN; step++) begin
                        idx = 0;
                        for (int k = ROW_LEN - 1; k >= 0; k--)
                            if (p2[k] == p1[pos]) idx = k;
                        pos = idx;
                        if (pos < lo || pos > hi) break;
                    end
                    kid[pos]    = p2[i];
                    filled[pos] = 1;
                end
            end
            for (int i = 0; i < ROW_LEN; i++)
                r.child_row[i*VALUE_BITS +: VALUE_BITS] = filled[i] ? kid[i] : p2[i];
            r.invalid = 1'b0;
            return r;
        endfunction

        function void note_parents(pmx_in_t w);
            pmx_out_t want;
            want = predict_child(w);
            words_in++;
            if (want.invalid) invalid_words++;
            if (w.cut_a >= ROW_LEN || w.cut_b >= ROW_LEN) clamped_cuts++;
            pending_children.push_back(want);
        endfunction

        function void check_child(pmx_out_t got);
            pmx_out_t want;
            words_checked++;
            if (pending_children.size() == 0) begin
                mismatches++;
                $display("%0t: child word with none pending: child %h invalid %0b",
                         $time, got.child_row, got.invalid);
                return;
            end
            want = pending_children.pop_front();
            if (got.child_row !== want.child_row) begin
                mismatches++;
                $display("%0t: child_row mismatch: expected %h actual %h",
                         $time, want.child_row, got.child_row);
            end
            if (got.invalid !== want.invalid) begin
                mismatches++;
                $display("%0t: invalid mismatch: expected %0b actual %0b",
                         $time, want.invalid, got.invalid);
            end
        endfunction

        function int outstanding();
            return pending_children.size();
        endfunction
    endclass

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pmx_in_t  s_word  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pmx_out_t m_word;

    crossover_checker chk;
    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    int stall_left      = 0;
    int idle_cycles     = 0;

    partially_mapped_crossover_row_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // note inputs before checking outputs in case both land on one edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) chk.note_parents(s_word);
            if (m_valid && m_ready) chk.check_child(m_word);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIM) begin
                $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: random stalls, with the odd long hold to back up the core
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 199) == 0) begin
            stall_left <= $urandom_range(20, 200);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic logic [POOL_W-1:0] shuffle_values(input logic [POOL_W-1:0] p,
                                                         input int n);
        logic [VALUE_BITS-1:0] t;
        int                    j;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = p[i*VALUE_BITS +: VALUE_BITS];
            p[i*VALUE_BITS +: VALUE_BITS] = p[j*VALUE_BITS +: VALUE_BITS];
            p[j*VALUE_BITS +: VALUE_BITS] = t;
        end
        return p;
    endfunction

    function automatic logic [CUT_W-1:0] rand_cut();
        if ($urandom_range(0, 9) == 0)
            return CUT_W'($urandom_range(ROW_LEN, MAX_CUT));
        return CUT_W'($urandom_range(0, ROW_LEN - 1));
    endfunction

    task automatic send_parents(input logic [ROW_W-1:0] first, input logic [ROW_W-1:0] second,
                                input logic [CUT_W-1:0] ca, input logic [CUT_W-1:0] cb);
        int gap;
        gap = 0;
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        if (sender_idle_pct != 0 && $urandom_range(0, 19) == 0)
            gap += $urandom_range(1, 100);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_word           <= '{first_row: first, second_row: second, cut_a: ca, cut_b: cb};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random_parents();
        logic [POOL_W-1:0] pool, tmp;
        logic [ROW_W-1:0]  first, second;
        logic [63:0]       noise;
        int                kind, a, b;
        kind = $urandom_range(0, 99);
        pool = '0;
        for (int i = 0; i < POOL_N; i++) pool[i*VALUE_BITS +: VALUE_BITS] = VALUE_BITS'(i);
        pool   = shuffle_values(pool, POOL_N);
        tmp    = shuffle_values(pool, ROW_LEN);
        first  = tmp[ROW_W-1:0];
        tmp    = shuffle_values(pool, ROW_LEN);
        second = tmp[ROW_W-1:0];
        if (kind >= 90) begin
            noise  = {$urandom(), $urandom()};
            first  = noise[ROW_W-1:0];
            noise  = {$urandom(), $urandom()};
            second = noise[ROW_W-1:0];
        end else if (kind >= 80) begin
            // repeat a value within one row
            a = $urandom_range(0, ROW_LEN - 1);
            b = (a + $urandom_range(1, ROW_LEN - 1)) % ROW_LEN;
            if (kind % 2)
                first[b*VALUE_BITS +: VALUE_BITS] = first[a*VALUE_BITS +: VALUE_BITS];
            else
                second[b*VALUE_BITS +: VALUE_BITS] = second[a*VALUE_BITS +: VALUE_BITS];
        end else if (kind >= 70) begin
            // swap in a value from outside the shared set
            a = $urandom_range(0, ROW_LEN - 1);
            second[a*VALUE_BITS +: VALUE_BITS] = pool[ROW_LEN*VALUE_BITS +: VALUE_BITS];
        end
        send_parents(first, second, rand_cut(), rand_cut());
    endtask

    initial begin
        chk = new();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        sender_idle_pct = 35;
        rx_stall_pct    = 45;
        // identity and reversed rows, full span and ordered/reversed cuts
        send_parents(36'h876543210, 36'h876543210, 4'd0, 4'd8);
        send_parents(36'h876543210, 36'h012345678, 4'd3, 4'd5);
        send_parents(36'h372816045, 36'h514870362, 4'd5, 4'd3);
        send_parents(36'h372816045, 36'h514870362, 4'd4, 4'd4);
        send_parents(36'h514870362, 36'h372816045, 4'd0, 4'd0);
        send_parents(36'h514870362, 36'h372816045, 4'd8, 4'd8);
        // cuts past the end clamp to the last position
        send_parents(36'h372816045, 36'h012345678, 4'd15, 4'd15);
        send_parents(36'h372816045, 36'h012345678, 4'd12, 4'd2);
        send_parents(36'h012345678, 36'h514870362, 4'd1, 4'd9);
        // longest mapping chase: second row is the first rotated by one
        send_parents(36'h876543210, 36'h087654321, 4'd0, 4'd7);
        send_parents(36'h876543210, 36'h087654321, 4'd1, 4'd8);
        send_parents(36'h087654321, 36'h876543210, 4'd7, 4'd1);
        // top of the value range
        send_parents(36'hFEDCBA987, 36'h8ECAFD7B9, 4'd2, 4'd6);
        send_parents(36'h8ECAFD7B9, 36'hFEDCBA987, 4'd6, 4'd0);
        // parents that are not permutations of one another
        send_parents(36'h000000000, 36'h000000000, 4'd0, 4'd8);
        send_parents(36'hFFFFFFFFF, 36'hFFFFFFFFF, 4'd3, 4'd3);
        send_parents(36'h876543210, 36'h976543210, 4'd2, 4'd5);
        send_parents(36'h876543200, 36'h876543210, 4'd0, 4'd4);
        send_parents(36'h876543210, 36'h886543210, 4'd4, 4'd8);
        send_parents(36'hFEDCBA987, 36'h876543210, 4'd0, 4'd8);
        repeat (140) send_random_parents();

        sender_idle_pct = 45;
        rx_stall_pct    = 35;
        repeat (150) send_random_parents();

        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        repeat (150) send_random_parents();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (chk.outstanding() != 0) @(posedge aclk);
        // hold a little longer to catch any stray child word
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d parent pairs sent, %0d child words checked, %0d flagged invalid, %0d with clamped cuts",
                 chk.words_in, chk.words_checked, chk.invalid_words, chk.clamped_cuts);
        $display("idling: sender-heavy, receiver-heavy and back-to-back phases");
        if (chk.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
